### sv/ile_pkg.sv
package ile_pkg;

    localparam int CAPACITY      = 256;
    localparam int ELEMENT_WIDTH = 32;
    localparam int ADDR_W        = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        OP_APPEND    = 3'd0,
        OP_INSERT    = 3'd1,
        OP_REMOVE    = 3'd2,
        OP_READ      = 3'd3,
        OP_OVERWRITE = 3'd4,
        OP_FIND      = 3'd5,
        OP_CLEAR     = 3'd6
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_NULL      = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic load;
        logic decode;
        logic scan;
        logic finish;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_req;
        logic scan_busy;
        logic out_free;
    } t_dp_sts;

endpackage

### sv/indexed_list_engine.sv
// ordered list of nonzero handles in a store of CAPACITY entries, one write and one read port
// input channel (i_in_valid / o_in_ready) carries one command item: opcode,
// position and element; output channel (o_out_valid / i_out_ready) returns one
// result item per command: status, value, found index and the new entry count
// commands are taken one at a time; a new item is accepted as soon as the
// previous one has been moved into the result register, even if that result
// is still waiting for the receiver
// append, overwrite, clear and any rejected command go from decode straight to
// the result; read, insert, remove and find first walk the store in a scan
// state and then pass a finish state, where insert writes its slot and insert
// and remove update the count; insert and remove shift the entries from the
// position to the end of the list, find stops at its first match, and these
// walks read the store one entry per cycle through its read port
// reset (synchronous, active low) empties the list and drops any pending
// result; store contents are not cleared, entries above the count are unused
// when the receiver stalls the result holds and the block waits before
// loading the next result
module indexed_list_engine import ile_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [2:0]               i_opcode,
    input  logic [CNT_W-1:0]         i_position,
    input  logic [ELEMENT_WIDTH-1:0] i_element,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [2:0]               o_status,
    output logic [ELEMENT_WIDTH-1:0] o_value_out,
    output logic [ADDR_W-1:0]        o_found_index,
    output logic [CNT_W-1:0]         o_entry_count
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ile_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    ile_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_opcode      (i_opcode),
        .i_position    (i_position),
        .i_element     (i_element),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_value_out   (o_value_out),
        .o_found_index (o_found_index),
        .o_entry_count (o_entry_count)
    );

endmodule

### sv/ile_ctrl.sv
module ile_ctrl import ile_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_FINISH = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = i_sts.scan_req ? S_SCAN : S_EMIT;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (!i_sts.scan_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/ile_dp.sv
module ile_dp import ile_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic [2:0]               i_opcode,
    input  logic [CNT_W-1:0]         i_position,
    input  logic [ELEMENT_WIDTH-1:0] i_element,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [2:0]               o_status,
    output logic [ELEMENT_WIDTH-1:0] o_value_out,
    output logic [ADDR_W-1:0]        o_found_index,
    output logic [CNT_W-1:0]         o_entry_count
);

    logic [ELEMENT_WIDTH-1:0] r_mem [CAPACITY];

    t_opcode                  r_op;
    logic [CNT_W-1:0]         r_pos;
    logic [ELEMENT_WIDTH-1:0] r_elem;
    logic [CNT_W-1:0]         r_count;
    logic [ADDR_W-1:0]        r_cur;
    logic [CNT_W-1:0]         r_left;
    logic                     r_dir_up;
    logic                     r_rd_vld;
    logic [ADDR_W-1:0]        r_rd_addr;
    logic [ELEMENT_WIDTH-1:0] r_rdata;
    logic                     r_hit;
    t_status                  r_res_status;
    logic [ELEMENT_WIDTH-1:0] r_res_value;
    logic [ADDR_W-1:0]        r_res_found;
    logic                     r_out_valid;
    logic [2:0]               r_out_status;
    logic [ELEMENT_WIDTH-1:0] r_out_value;
    logic [ADDR_W-1:0]        r_out_found;
    logic [CNT_W-1:0]         r_out_count;

    logic                     w_null;
    logic                     w_full;
    logic                     w_pos_gt;
    logic                     w_pos_ge;
    logic                     w_hit_now;
    logic                     w_re;
    logic                     w_we;
    logic [ADDR_W-1:0]        w_waddr;
    logic [ELEMENT_WIDTH-1:0] w_wdata;
    logic                     w_first_rm;
    t_status                  w_dec_status;
    logic                     w_scan_req;

    assign w_null     = (r_elem == '0);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_pos_gt   = (r_pos > r_count);
    assign w_pos_ge   = (r_pos >= r_count);
    assign w_first_rm = (r_rd_addr == r_pos[ADDR_W-1:0]);
    assign w_hit_now  = r_rd_vld && (r_op == OP_FIND) && !r_hit && (r_rdata == r_elem);
    assign w_re       = i_cmd.scan && (r_left != '0) && !w_hit_now;

    // command checks, null first, then index, then full
    always_comb begin
        w_dec_status = ST_OK;
        w_scan_req   = 1'b0;
        unique case (r_op)
            OP_APPEND: begin
                priority if (w_null) w_dec_status = ST_NULL;
                else if (w_full)     w_dec_status = ST_FULL;
                else                 w_dec_status = ST_OK;
            end
            OP_INSERT: begin
                priority if (w_null) w_dec_status = ST_NULL;
                else if (w_pos_gt)   w_dec_status = ST_BAD_INDEX;
                else if (w_full)     w_dec_status = ST_FULL;
                else begin
                    w_dec_status = ST_OK;
                    w_scan_req   = 1'b1;
                end
            end
            OP_REMOVE, OP_READ: begin
                if (w_pos_ge) begin
                    w_dec_status = ST_BAD_INDEX;
                end else begin
                    w_scan_req = 1'b1;
                end
            end
            OP_OVERWRITE: begin
                priority if (w_null) w_dec_status = ST_NULL;
                else if (w_pos_ge)   w_dec_status = ST_BAD_INDEX;
                else                 w_dec_status = ST_OK;
            end
            OP_FIND: begin
                if (w_null) begin
                    w_dec_status = ST_NULL;
                end else begin
                    w_dec_status = ST_NOT_FOUND;
                    w_scan_req   = 1'b1;
                end
            end
            default: begin
                w_dec_status = ST_OK;
            end
        endcase
    end

    // single write port: direct writes, shifted entries, final insert slot
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[ADDR_W-1:0];
        w_wdata = r_elem;
        if (i_cmd.decode) begin
            if (r_op == OP_APPEND && !w_null && !w_full) begin
                w_we = 1'b1;
            end else if (r_op == OP_OVERWRITE && !w_null && !w_pos_ge) begin
                w_we    = 1'b1;
                w_waddr = r_pos[ADDR_W-1:0];
            end
        end else if (i_cmd.scan && r_rd_vld) begin
            if (r_op == OP_INSERT) begin
                w_we    = 1'b1;
                w_waddr = r_rd_addr + 1'b1;
                w_wdata = r_rdata;
            end else if (r_op == OP_REMOVE && !w_first_rm) begin
                w_we    = 1'b1;
                w_waddr = r_rd_addr - 1'b1;
                w_wdata = r_rdata;
            end
        end else if (i_cmd.finish && r_op == OP_INSERT) begin
            w_we    = 1'b1;
            w_waddr = r_pos[ADDR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[r_cur];
        end
    end

    // command and scan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_left   <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_rd_vld <= w_re;
            if (i_cmd.load) begin
                r_op   <= t_opcode'(i_opcode);
                r_pos  <= i_position;
                r_elem <= i_element;
            end
            if (i_cmd.decode) begin
                r_res_status <= w_dec_status;
                r_res_value  <= '0;
                r_res_found  <= '0;
                r_hit        <= 1'b0;
                r_left       <= '0;
                if (w_scan_req) begin
                    unique case (r_op)
                        OP_INSERT: begin
                            r_left   <= r_count - r_pos;
                            r_cur    <= ADDR_W'(r_count - 1'b1);
                            r_dir_up <= 1'b0;
                        end
                        OP_REMOVE: begin
                            r_left   <= r_count - r_pos;
                            r_cur    <= r_pos[ADDR_W-1:0];
                            r_dir_up <= 1'b1;
                        end
                        OP_READ: begin
                            r_left   <= CNT_W'(1);
                            r_cur    <= r_pos[ADDR_W-1:0];
                            r_dir_up <= 1'b1;
                        end
                        default: begin
                            r_left   <= r_count;
                            r_cur    <= '0;
                            r_dir_up <= 1'b1;
                        end
                    endcase
                end
                if (r_op == OP_APPEND && !w_null && !w_full) begin
                    r_count <= r_count + 1'b1;
                end else if (r_op == OP_CLEAR) begin
                    r_count <= '0;
                end
            end
            if (w_re) begin
                r_cur     <= r_dir_up ? r_cur + 1'b1 : r_cur - 1'b1;
                r_left    <= r_left - 1'b1;
                r_rd_addr <= r_cur;
            end
            if (w_hit_now) begin
                r_hit        <= 1'b1;
                r_left       <= '0;
                r_res_status <= ST_OK;
                r_res_found  <= r_rd_addr;
            end
            // the first entry read by remove is the one taken out
            if (i_cmd.scan && r_rd_vld &&
                (r_op == OP_READ || (r_op == OP_REMOVE && w_first_rm))) begin
                r_res_value <= r_rdata;
            end
            if (i_cmd.finish) begin
                if (r_op == OP_INSERT) begin
                    r_count <= r_count + 1'b1;
                end else if (r_op == OP_REMOVE) begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
            r_out_found  <= r_res_found;
            r_out_count  <= r_count;
        end
    end

    assign o_sts.scan_req  = w_scan_req;
    assign o_sts.scan_busy = (r_left != '0) || r_rd_vld;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_value_out   = r_out_value;
    assign o_found_index = r_out_found;
    assign o_entry_count = r_out_count;

endmodule
